>>> design/tpdn_pkg.sv
// shared types, constants and helper functions of the pid duplicator with null reuse
// used by every module of the block; depends on nothing
package tpdn_pkg;

    // sizes of the packet queue and of the pid map
    localparam int QUEUE_PACKETS = 64;
    localparam int MAP_ENTRIES   = 4;
    localparam int PKT_WORDS     = 47;

    // field widths
    localparam int WORD_W    = 32;
    localparam int PID_W     = 13;
    localparam int PID_LO    = 8;
    localparam int ENTRY_W   = 27;
    localparam int MAXBUF_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int USER_W    = 3;

    // layout of one map entry
    localparam int ENT_VALID_BIT = 26;
    localparam int ENT_SRC_LO    = 13;
    localparam int ENT_SRC_HI    = 25;

    // derived widths
    localparam int SLOT_W  = (QUEUE_PACKETS > 1) ? $clog2(QUEUE_PACKETS) : 1;
    localparam int POS_W   = $clog2(PKT_WORDS);
    localparam int ADDR_W  = $clog2(QUEUE_PACKETS * PKT_WORDS);
    localparam int COUNT_W = $clog2(QUEUE_PACKETS + 1);
    localparam int RAM_DEPTH = QUEUE_PACKETS * PKT_WORDS;

    // output buffer
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK   = 3'd5;

    localparam logic [MAXBUF_W-1:0] MAX_BUF_RESET = 7'd64;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [PID_W-1:0]   t_pid;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [MAP_ENTRIES-1:0][ENTRY_W-1:0] map;
        logic [MAXBUF_W-1:0]                 max_buf;
        logic                                check;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_word word;
        logic  last;
        logic  inserted;
        logic  overflow;
        logic  conflict;
    } t_result;

    // queue memory ports
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_ram_rd;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_word data;
    } t_ram_wr;

    // control status toward the top level
    typedef struct packed {
        logic   b_valid;
        logic   halted;
        t_count count;
    } t_ctl_status;

    // next slot of the circular queue
    function automatic t_slot next_slot(t_slot s);
        return (s == t_slot'(QUEUE_PACKETS - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

    // memory address of one word of one slot
    function automatic t_addr slot_addr(t_slot s, t_pos p);
        return t_addr'(t_addr'(s) * t_addr'(PKT_WORDS) + t_addr'(p));
    endfunction

endpackage

>>> design/tpdn_cfg_regs.sv
// configuration registers: pid map entries, queue limit, conflict check enable
// depends on tpdn_pkg
module tpdn_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpdn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpdn_pkg::ENTRY_W-1:0]      i_cfg_data,
    output tpdn_pkg::t_cfg                    o_cfg
);

    tpdn_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map     <= '0;
            r_cfg.max_buf <= tpdn_pkg::MAX_BUF_RESET;
            r_cfg.check   <= 1'b1;
        end else if (i_cfg_we) begin
            for (int e = 0; e < tpdn_pkg::MAP_ENTRIES; e++) begin
                if (i_cfg_index == tpdn_pkg::CFG_MAP_0 + tpdn_pkg::CFG_IDX_W'(e)) begin
                    r_cfg.map[e] <= i_cfg_data;
                end
            end
            if (i_cfg_index == tpdn_pkg::CFG_MAX_BUF) begin
                r_cfg.max_buf <= i_cfg_data[tpdn_pkg::MAXBUF_W-1:0];
            end
            if (i_cfg_index == tpdn_pkg::CFG_CHECK) begin
                r_cfg.check <= i_cfg_data[0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/tpdn_queue_ram.sv
// packet queue storage: one write port, one read port, registered read data
// depends on tpdn_pkg
module tpdn_queue_ram (
    input  logic               i_clk,
    input  tpdn_pkg::t_ram_wr  i_wr,
    input  tpdn_pkg::t_ram_rd  i_rd,
    output tpdn_pkg::t_word    o_rdata
);

    tpdn_pkg::t_word r_mem [tpdn_pkg::RAM_DEPTH];
    tpdn_pkg::t_word r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tpdn_ctrl.sv
// packet decision on word 0, queue pointers, replacement read and copy write-back
// depends on tpdn_pkg; drives tpdn_queue_ram ports
module tpdn_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tpdn_pkg::t_cfg        i_cfg,
    input  logic                  i_accept,
    input  tpdn_pkg::t_word       i_word,
    input  tpdn_pkg::t_word       i_rdata,
    output tpdn_pkg::t_ram_rd     o_rd,
    output tpdn_pkg::t_ram_wr     o_wr,
    output logic                  o_res_valid,
    output tpdn_pkg::t_result     o_res,
    output tpdn_pkg::t_ctl_status o_status
);

    // packet state
    tpdn_pkg::t_pos   r_pos;
    tpdn_pkg::t_slot  r_head;
    tpdn_pkg::t_slot  r_tail;
    tpdn_pkg::t_count r_count;
    logic             r_repl;
    logic             r_copy;
    logic             r_halted;
    tpdn_pkg::t_slot  r_rd_slot;
    tpdn_pkg::t_pid   r_dup_pid;

    // second stage, waits for the registered memory read data
    logic             r_b_valid;
    tpdn_pkg::t_word  r_b_word;
    logic             r_b_last;
    logic             r_b_repl;
    logic             r_b_ovf;
    logic             r_b_conf;
    logic             r_b_copy;
    logic             r_b_pos0;
    tpdn_pkg::t_pid   r_b_dup;
    tpdn_pkg::t_addr  r_b_waddr;

    // decision signals
    tpdn_pkg::t_pid   pid;
    logic             found;
    logic             is_target;
    tpdn_pkg::t_pid   new_pid;
    logic             conflict;
    logic             pop;
    logic             drop;
    tpdn_pkg::t_count cnt_a;
    tpdn_pkg::t_count limit;
    tpdn_pkg::t_slot  head_a;
    logic             pos0;
    logic             pos_last;
    logic             repl_eff;
    logic             copy_eff;
    tpdn_pkg::t_slot  rd_slot_eff;
    tpdn_pkg::t_pid   dup_eff;
    logic             work;
    tpdn_pkg::t_word  out_word;

    // map lookup, lowest valid matching entry wins
    always_comb begin
        pid       = i_word[tpdn_pkg::PID_LO +: tpdn_pkg::PID_W];
        found     = 1'b0;
        is_target = 1'b0;
        new_pid   = '0;
        for (int e = 0; e < tpdn_pkg::MAP_ENTRIES; e++) begin
            if (i_cfg.map[e][tpdn_pkg::ENT_VALID_BIT]) begin
                if (!found &&
                    i_cfg.map[e][tpdn_pkg::ENT_SRC_HI:tpdn_pkg::ENT_SRC_LO] == pid) begin
                    found   = 1'b1;
                    new_pid = i_cfg.map[e][tpdn_pkg::PID_W-1:0];
                end
                if (i_cfg.map[e][tpdn_pkg::PID_W-1:0] == pid) begin
                    is_target = 1'b1;
                end
            end
        end
    end

    // queue limit clamped to 1..QUEUE_PACKETS
    always_comb begin
        if (i_cfg.max_buf == '0) begin
            limit = tpdn_pkg::t_count'(1);
        end else if (32'(i_cfg.max_buf) > tpdn_pkg::QUEUE_PACKETS) begin
            limit = tpdn_pkg::t_count'(tpdn_pkg::QUEUE_PACKETS);
        end else begin
            limit = tpdn_pkg::t_count'(i_cfg.max_buf);
        end
    end

    // word 0 decisions: replacement pop first, then drop of the oldest
    assign pos0     = (r_pos == '0);
    assign pos_last = (r_pos == tpdn_pkg::t_pos'(tpdn_pkg::PKT_WORDS - 1));
    assign conflict = i_cfg.check && !found && is_target;
    assign pop      = (pid == tpdn_pkg::NULL_PID) && (r_count != '0);
    assign cnt_a    = r_count - tpdn_pkg::t_count'(pop);
    assign head_a   = pop ? tpdn_pkg::next_slot(r_head) : r_head;
    assign drop     = found && (cnt_a >= limit) && (cnt_a != '0);

    assign repl_eff    = pos0 ? pop : r_repl;
    assign copy_eff    = pos0 ? found : r_copy;
    assign rd_slot_eff = pos0 ? r_head : r_rd_slot;
    assign dup_eff     = pos0 ? new_pid : r_dup_pid;
    assign work        = i_accept && !r_halted && !(pos0 && conflict);

    // replacement read issued in the accept cycle
    assign o_rd.en   = work && repl_eff;
    assign o_rd.addr = tpdn_pkg::slot_addr(rd_slot_eff, r_pos);

    // packet state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_repl    <= 1'b0;
            r_copy    <= 1'b0;
            r_halted  <= 1'b0;
            r_rd_slot <= '0;
            r_dup_pid <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_accept && !r_halted;
            if (i_accept && !r_halted && pos0 && conflict) begin
                r_halted <= 1'b1;
            end
            if (work) begin
                if (pos0) begin
                    r_head    <= drop ? tpdn_pkg::next_slot(head_a) : head_a;
                    r_count   <= cnt_a - tpdn_pkg::t_count'(drop) + tpdn_pkg::t_count'(found);
                    r_rd_slot <= r_head;
                    r_dup_pid <= new_pid;
                end
                if (pos_last) begin
                    r_pos  <= '0;
                    r_repl <= 1'b0;
                    r_copy <= 1'b0;
                    if (copy_eff) begin
                        r_tail <= tpdn_pkg::next_slot(r_tail);
                    end
                end else begin
                    r_pos  <= r_pos + 1'b1;
                    r_repl <= repl_eff;
                    r_copy <= copy_eff;
                end
            end
        end
    end

    // second stage payload
    always_ff @(posedge i_clk) begin
        r_b_word  <= i_word;
        r_b_last  <= pos_last;
        r_b_repl  <= repl_eff;
        r_b_ovf   <= pos0 && drop;
        r_b_conf  <= pos0 && conflict;
        r_b_copy  <= work && copy_eff;
        r_b_pos0  <= pos0;
        r_b_dup   <= dup_eff;
        r_b_waddr <= tpdn_pkg::slot_addr(r_tail, r_pos);
    end

    // output word and copy write-back with the duplicate pid on word 0
    assign out_word = r_b_repl ? i_rdata : r_b_word;

    always_comb begin
        o_wr.en   = r_b_valid && r_b_copy;
        o_wr.addr = r_b_waddr;
        o_wr.data = out_word;
        if (r_b_pos0) begin
            o_wr.data[tpdn_pkg::PID_LO +: tpdn_pkg::PID_W] = r_b_dup;
        end
    end

    // result item, the conflict item carries only its flag
    always_comb begin
        o_res_valid = r_b_valid;
        if (r_b_conf) begin
            o_res.word     = '0;
            o_res.last     = 1'b0;
            o_res.inserted = 1'b0;
            o_res.overflow = 1'b0;
            o_res.conflict = 1'b1;
        end else begin
            o_res.word     = out_word;
            o_res.last     = r_b_last;
            o_res.inserted = r_b_repl;
            o_res.overflow = r_b_ovf;
            o_res.conflict = 1'b0;
        end
    end

    assign o_status.b_valid = r_b_valid;
    assign o_status.halted  = r_halted;
    assign o_status.count   = r_count;

endmodule

>>> design/tpdn_out_fifo.sv
// three-entry output buffer between the datapath and the result stream
// depends on tpdn_pkg
module tpdn_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  tpdn_pkg::t_result                 i_item,
    input  logic                              i_ready,
    output logic                              o_valid,
    output tpdn_pkg::t_result                 o_item,
    output logic [tpdn_pkg::FIFO_CNT_W-1:0]   o_count
);

    tpdn_pkg::t_result                  r_mem [tpdn_pkg::FIFO_DEPTH];
    logic [tpdn_pkg::FIFO_PTR_W-1:0]    r_wp;
    logic [tpdn_pkg::FIFO_PTR_W-1:0]    r_rp;
    logic [tpdn_pkg::FIFO_CNT_W-1:0]    r_cnt;
    logic                               pop;

    assign pop = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == tpdn_pkg::FIFO_PTR_W'(tpdn_pkg::FIFO_DEPTH - 1)) ?
                        '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == tpdn_pkg::FIFO_PTR_W'(tpdn_pkg::FIFO_DEPTH - 1)) ?
                        '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + tpdn_pkg::FIFO_CNT_W'(i_push) - tpdn_pkg::FIFO_CNT_W'(pop);
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

>>> design/ts_pid_duplicator_null_reuse.sv
// top level of the pid duplicator with null packet reuse
// depends on tpdn_pkg, tpdn_cfg_regs, tpdn_ctrl, tpdn_queue_ram, tpdn_out_fifo
//
// channel    direction  handshake                  payload
// s_axis     in         s_axis_tvalid/tready       tdata = in_word
// m_axis     out        m_axis_tvalid/tready       tdata = out_word, tlast = end_of_packet,
//                                                  tuser = inserted, overflow, conflict
// cfg        in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item per cycle sustained while m_axis_tready is high; a result is registered in the
// second stage, beside the registered queue memory read, and then in the output buffer
// reset is synchronous and needs no clearing pass: queue words are read only after written
// s_axis_tready drops when the three-entry output buffer and the item in flight fill it
// after a pid conflict items are still taken but give no result until reset
module ts_pid_duplicator_null_reuse (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] in_word
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] out_word
    output logic                              m_axis_tlast,
    output logic [tpdn_pkg::USER_W-1:0]       m_axis_tuser,   // [0] inserted [1] overflow
                                                              // [2] conflict
    input  logic                              i_cfg_we,
    input  logic [tpdn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpdn_pkg::ENTRY_W-1:0]      i_cfg_data
);

    tpdn_pkg::t_cfg                       cfg;
    tpdn_pkg::t_ram_rd                    ram_rd;
    tpdn_pkg::t_ram_wr                    ram_wr;
    tpdn_pkg::t_word                      ram_rdata;
    logic                                 res_valid;
    tpdn_pkg::t_result                    res;
    tpdn_pkg::t_ctl_status                status;
    tpdn_pkg::t_result                    out_item;
    logic [tpdn_pkg::FIFO_CNT_W-1:0]      fifo_cnt;
    logic                                 accept;

    // room for the item in flight plus one more
    assign s_axis_tready = ({1'b0, fifo_cnt} + 3'(status.b_valid)) < 3'(tpdn_pkg::FIFO_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    tpdn_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tpdn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_word      (s_axis_tdata),
        .i_rdata     (ram_rdata),
        .o_rd        (ram_rd),
        .o_wr        (ram_wr),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_status    (status)
    );

    tpdn_queue_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_rd    (ram_rd),
        .o_rdata (ram_rdata)
    );

    tpdn_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_item  (out_item),
        .o_count (fifo_cnt)
    );

    assign m_axis_tdata = out_item.word;
    assign m_axis_tlast = out_item.last;
    assign m_axis_tuser = {out_item.conflict, out_item.overflow, out_item.inserted};

    // a replacement read never hits the word being written back in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_rd.en && ram_wr.en) |-> (ram_rd.addr != ram_wr.addr))
        else $error("queue read and write to the same word");

    // once halted, no result after the conflict item
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.halted && $past(status.halted)) |-> !res_valid)
        else $error("result after conflict halt");

    // the output buffer always has room for the item leaving the datapath
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (fifo_cnt < tpdn_pkg::FIFO_CNT_W'(tpdn_pkg::FIFO_DEPTH)))
        else $error("output buffer overrun");

    // queued packet count stays within the queue
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(status.count) <= tpdn_pkg::QUEUE_PACKETS)
        else $error("queued packet count out of range");

endmodule

>>> bench/tb_ts_pid_duplicator_null_reuse.sv
// self-checking bench for the pid duplicator with null packet reuse
// holds its own packet-queue predictor, a stream driver and a result monitor
// depends on tpdn_pkg and ts_pid_duplicator_null_reuse
module tb_ts_pid_duplicator_null_reuse;
    timeunit 1ns;
    timeprecision 1ps;

    // config indexes past the last register, which the block must ignore
    localparam logic [tpdn_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [tpdn_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // tuser bit positions
    localparam int USER_INSERTED = 0;
    localparam int USER_OVERFLOW = 1;
    localparam int USER_CONFLICT = 2;

    localparam int BODY_WORDS  = tpdn_pkg::PKT_WORDS - 1;
    localparam int SPLIT_WORDS = 19;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 2000;

    // pids used by the directed packets
    localparam logic [tpdn_pkg::PID_W-1:0] PID_A = 13'h0100;
    localparam logic [tpdn_pkg::PID_W-1:0] PID_B = 13'h0200;
    localparam logic [tpdn_pkg::PID_W-1:0] PID_C = 13'h0300;
    localparam logic [tpdn_pkg::PID_W-1:0] PID_D = 13'h0400;
    localparam logic [tpdn_pkg::PID_W-1:0] PID_E = 13'h0000;
    localparam logic [tpdn_pkg::PID_W-1:0] PID_F = 13'h1FFE;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} t_rx_mode;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [31:0]                       s_axis_tdata = '0;   // [31:0] in_word
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [31:0]                       m_axis_tdata;        // [31:0] out_word
    logic                              m_axis_tlast;
    logic [tpdn_pkg::USER_W-1:0]       m_axis_tuser;        // [0] inserted [1] overflow
                                                            // [2] conflict
    logic                              i_cfg_we = 1'b0;
    logic [tpdn_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [tpdn_pkg::ENTRY_W-1:0]      i_cfg_data = '0;

    ts_pid_duplicator_null_reuse DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // register copies as the block should hold them
    bit [tpdn_pkg::ENTRY_W-1:0]  map_copy [tpdn_pkg::MAP_ENTRIES] = '{default: '0};
    bit [tpdn_pkg::MAXBUF_W-1:0] maxbuf_copy = tpdn_pkg::MAX_BUF_RESET;
    bit                          check_copy = 1'b1;

    // predicted packet queue and stream position
    bit [31:0]                 pkt_store [tpdn_pkg::RAM_DEPTH];
    int unsigned               q_head = 0;
    int unsigned               q_tail = 0;
    int unsigned               q_count = 0;
    int unsigned               w_pos = 0;
    int unsigned               rd_slot = 0;
    bit                        repl_on = 1'b0;
    bit                        copy_on = 1'b0;
    bit                        stream_dead = 1'b0;
    bit [tpdn_pkg::PID_W-1:0]  dup_pid_now = '0;

    tpdn_pkg::t_result         out_words_due [$];
    bit [31:0]                 words_to_send [$];
    int unsigned               words_pushed = 0;
    int unsigned               words_taken = 0;
    int unsigned               mismatches = 0;
    bit [tpdn_pkg::PID_W-1:0]  pid_pool [6];

    // advance the predicted block by one input word
    task automatic duplicator_step(input bit [31:0] w);
        tpdn_pkg::t_result        r;
        bit [tpdn_pkg::PID_W-1:0] pid;
        bit [tpdn_pkg::PID_W-1:0] hit_dup;
        bit                       hit;
        bit                       is_target;
        bit                       dropped;
        bit [31:0]                ow;
        bit [31:0]                cw;
        int unsigned              lim;
        r = '0;
        dropped = 1'b0;
        hit = 1'b0;
        is_target = 1'b0;
        hit_dup = '0;
        if (!stream_dead) begin
            // packet decision on the header word
            if (w_pos == 0) begin
                pid = w[tpdn_pkg::PID_LO +: tpdn_pkg::PID_W];
                for (int i = 0; i < tpdn_pkg::MAP_ENTRIES; i++) begin
                    if (map_copy[i][tpdn_pkg::ENT_VALID_BIT]) begin
                        if (!hit &&
                            map_copy[i][tpdn_pkg::ENT_SRC_HI:tpdn_pkg::ENT_SRC_LO] == pid) begin
                            hit = 1'b1;
                            hit_dup = map_copy[i][tpdn_pkg::PID_W-1:0];
                        end
                        if (map_copy[i][tpdn_pkg::PID_W-1:0] == pid)
                            is_target = 1'b1;
                    end
                end
                if (check_copy && !hit && is_target) begin
                    stream_dead = 1'b1;
                end else begin
                    repl_on = 1'b0;
                    if (pid == tpdn_pkg::NULL_PID && q_count > 0) begin
                        rd_slot = q_head;
                        q_head = (q_head + 1) % tpdn_pkg::QUEUE_PACKETS;
                        q_count--;
                        repl_on = 1'b1;
                    end
                    copy_on = hit;
                    if (hit) begin
                        lim = 32'(maxbuf_copy);
                        if (lim < 1)
                            lim = 1;
                        if (lim > tpdn_pkg::QUEUE_PACKETS)
                            lim = tpdn_pkg::QUEUE_PACKETS;
                        if (q_count >= lim && q_count > 0) begin
                            q_head = (q_head + 1) % tpdn_pkg::QUEUE_PACKETS;
                            q_count--;
                            dropped = 1'b1;
                        end
                        dup_pid_now = hit_dup;
                    end
                end
            end
            if (stream_dead) begin
                // the single conflict marker
                r.conflict = 1'b1;
                out_words_due.insert(out_words_due.size(), r);
            end else begin
                ow = repl_on ? pkt_store[rd_slot * tpdn_pkg::PKT_WORDS + w_pos] : w;
                if (copy_on) begin
                    cw = ow;
                    if (w_pos == 0)
                        cw[tpdn_pkg::PID_LO +: tpdn_pkg::PID_W] = dup_pid_now;
                    pkt_store[q_tail * tpdn_pkg::PKT_WORDS + w_pos] = cw;
                    if (w_pos == 0)
                        q_count++;
                    if (w_pos == tpdn_pkg::PKT_WORDS - 1)
                        q_tail = (q_tail + 1) % tpdn_pkg::QUEUE_PACKETS;
                end
                r.word = ow;
                r.last = (w_pos == tpdn_pkg::PKT_WORDS - 1);
                r.inserted = repl_on;
                r.overflow = dropped;
                out_words_due.insert(out_words_due.size(), r);
                w_pos++;
                if (w_pos >= tpdn_pkg::PKT_WORDS) begin
                    w_pos = 0;
                    repl_on = 1'b0;
                    copy_on = 1'b0;
                end
            end
        end
    endtask

    // true when a header with this pid would halt the stream
    function automatic bit pid_halts(input bit [tpdn_pkg::PID_W-1:0] pid);
        bit hit;
        bit is_target;
        hit = 1'b0;
        is_target = 1'b0;
        for (int i = 0; i < tpdn_pkg::MAP_ENTRIES; i++) begin
            if (map_copy[i][tpdn_pkg::ENT_VALID_BIT]) begin
                if (map_copy[i][tpdn_pkg::ENT_SRC_HI:tpdn_pkg::ENT_SRC_LO] == pid)
                    hit = 1'b1;
                if (map_copy[i][tpdn_pkg::PID_W-1:0] == pid)
                    is_target = 1'b1;
            end
        end
        return check_copy && !hit && is_target;
    endfunction

    // header pid biased toward null, mapped sources and targets
    function automatic bit [tpdn_pkg::PID_W-1:0] pick_pid();
        bit [tpdn_pkg::PID_W-1:0] pid;
        int unsigned              roll;
        do begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                pid = tpdn_pkg::NULL_PID;
            else if (roll < 60)
                pid = map_copy[$urandom_range(0, tpdn_pkg::MAP_ENTRIES - 1)]
                              [tpdn_pkg::ENT_SRC_HI:tpdn_pkg::ENT_SRC_LO];
            else if (roll < 72)
                pid = map_copy[$urandom_range(0, tpdn_pkg::MAP_ENTRIES - 1)]
                              [tpdn_pkg::PID_W-1:0];
            else if (roll < 82)
                pid = pid_pool[$urandom_range(0, 5)];
            else
                pid = 13'($urandom_range(0, 8191));
        end while (pid_halts(pid));
        return pid;
    endfunction

    function automatic bit [tpdn_pkg::ENTRY_W-1:0] map_word(input bit v,
                                                            input bit [tpdn_pkg::PID_W-1:0] src,
                                                            input bit [tpdn_pkg::PID_W-1:0] dup);
        return {v, src, dup};
    endfunction

    task automatic queue_body(input int n);
        repeat (n) begin
            words_to_send.insert(words_to_send.size(), $urandom);
            words_pushed++;
        end
    endtask

    task automatic queue_packet(input bit [tpdn_pkg::PID_W-1:0] pid, input int body);
        bit [31:0] hdr;
        hdr = $urandom;
        hdr[tpdn_pkg::PID_LO +: tpdn_pkg::PID_W] = pid;
        words_to_send.insert(words_to_send.size(), hdr);
        words_pushed++;
        queue_body(body);
    endtask

    // one register write per clock; the caller lowers the enable afterwards
    task automatic write_reg(input logic [tpdn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpdn_pkg::ENTRY_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx >= tpdn_pkg::CFG_MAP_0 &&
            int'(idx) < int'(tpdn_pkg::CFG_MAP_0) + tpdn_pkg::MAP_ENTRIES)
            map_copy[int'(idx - tpdn_pkg::CFG_MAP_0)] = data;
        else if (idx == tpdn_pkg::CFG_MAX_BUF)
            maxbuf_copy = data[tpdn_pkg::MAXBUF_W-1:0];
        else if (idx == tpdn_pkg::CFG_CHECK)
            check_copy = data[0];
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [tpdn_pkg::ENTRY_W-1:0] e0,
                                 input logic [tpdn_pkg::ENTRY_W-1:0] e1,
                                 input logic [tpdn_pkg::ENTRY_W-1:0] e2,
                                 input logic [tpdn_pkg::ENTRY_W-1:0] e3,
                                 input logic [tpdn_pkg::MAXBUF_W-1:0] mb, input logic chk);
        write_reg(tpdn_pkg::CFG_MAP_0, e0);
        write_reg(tpdn_pkg::CFG_MAP_0 + 3'd1, e1);
        write_reg(tpdn_pkg::CFG_MAP_0 + 3'd2, e2);
        write_reg(tpdn_pkg::CFG_MAP_0 + 3'd3, e3);
        write_reg(tpdn_pkg::CFG_MAX_BUF, tpdn_pkg::ENTRY_W'(mb));
        write_reg(tpdn_pkg::CFG_CHECK, tpdn_pkg::ENTRY_W'(chk));
        end_writes();
    endtask

    // wait until every item is taken and every result is back
    task automatic drain();
        while (words_taken != words_pushed || out_words_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // sender: bursts of random length with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                duplicator_step(s_axis_tdata);
                words_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= words_to_send[0];
                    words_to_send.delete(0);
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: result checks and its own stall pattern
    t_rx_mode          rx_mode = RX_FREE;
    int unsigned       mode_left = 0;
    int unsigned       hold_left = 0;
    bit                hold_armed = 1'b0;
    bit                hold_taken = 1'b0;
    tpdn_pkg::t_result due;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (out_words_due.size() == 0) begin
                    $error("unexpected result item: out_word %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    due = out_words_due[0];
                    out_words_due.delete(0);
                    check_field("out_word", due.word, m_axis_tdata);
                    check_field("end_of_packet", 32'(due.last), 32'(m_axis_tlast));
                    check_field("inserted", 32'(due.inserted),
                                32'(m_axis_tuser[USER_INSERTED]));
                    check_field("overflow", 32'(due.overflow),
                                32'(m_axis_tuser[USER_OVERFLOW]));
                    check_field("conflict", 32'(due.conflict),
                                32'(m_axis_tuser[USER_CONFLICT]));
                end
            end
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    int unsigned stall_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [tpdn_pkg::ENTRY_W-1:0]  ent [tpdn_pkg::MAP_ENTRIES];
        logic [tpdn_pkg::MAXBUF_W-1:0] mb;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: nothing mapped, a null packet passes with an empty queue
        queue_packet(tpdn_pkg::NULL_PID, BODY_WORDS);
        drain();

        // two entries on one source, null mapped, limit of zero, no checking
        apply_setting(map_word(1'b1, PID_A, PID_B), map_word(1'b1, PID_A, PID_C),
                      map_word(1'b1, tpdn_pkg::NULL_PID, PID_D), map_word(1'b1, PID_E, PID_F),
                      7'd0, 1'b0);
        write_reg(CFG_SPARE_LO, {tpdn_pkg::ENTRY_W{1'b1}});
        write_reg(CFG_SPARE_HI, '0);
        end_writes();
        queue_packet(PID_A, BODY_WORDS);
        queue_packet(PID_A, SPLIT_WORDS);
        hold_armed = 1'b1;
        drain();

        // limit raised in the middle of a packet
        write_reg(tpdn_pkg::CFG_MAX_BUF, tpdn_pkg::ENTRY_W'(2));
        end_writes();
        queue_body(BODY_WORDS - SPLIT_WORDS);
        queue_packet(PID_A, BODY_WORDS);
        queue_packet(PID_E, BODY_WORDS);
        queue_packet(tpdn_pkg::NULL_PID, BODY_WORDS);
        queue_packet(PID_F, BODY_WORDS);
        queue_packet(tpdn_pkg::NULL_PID, BODY_WORDS);
        drain();

        // random settings with a random packet mix
        for (int k = 0; k < 6; k++)
            pid_pool[k] = 13'($urandom_range(0, 8191));
        if ($urandom_range(0, 1))
            pid_pool[0] = tpdn_pkg::NULL_PID;
        for (int e = 0; e < tpdn_pkg::MAP_ENTRIES; e++)
            ent[e] = map_word($urandom_range(0, 3) != 0, pid_pool[$urandom_range(0, 5)],
                              pid_pool[$urandom_range(0, 5)]);
        case ($urandom_range(0, 6))
            0:       mb = 7'd0;
            1:       mb = 7'd1;
            2:       mb = 7'd2;
            3:       mb = 7'd64;
            4:       mb = 7'd127;
            5:       mb = 7'($urandom_range(0, 127));
            default: mb = 7'($urandom_range(1, 8));
        endcase
        apply_setting(ent[0], ent[1], ent[2], ent[3], mb, 1'($urandom_range(0, 1)));
        repeat (2) queue_packet(pick_pid(), BODY_WORDS);
        drain();

        // conflict halt: the stream stops for good, later items give nothing
        apply_setting(map_word(1'b1, PID_A, PID_B), '0, '0, '0, 7'd64, 1'b1);
        queue_packet(tpdn_pkg::NULL_PID, BODY_WORDS);
        queue_packet(PID_B, 8);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
